>>> rtl/rtfs_pkg.sv
// shared types and constants for the rgb triangle fade sequencer
// no dependencies; imported by rtfs_ctrl, rtfs_dp and the top level
package rtfs_pkg;

    // time arithmetic width; input times and differences wrap at this width
    localparam int TIME_WIDTH = 32;

    localparam int NOW_W      = 32;
    localparam int LEVEL_W    = 8;
    localparam int PROD_W     = 2 * LEVEL_W;
    localparam int WAIT_W     = 16;
    localparam int REPEAT_W   = 16;
    localparam int NUM_LANES  = 3;
    localparam int DIV_STEPS  = PROD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WAIT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FADE_STEPS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FADE_REPEATS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_RED     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_GREEN   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_BLUE    = 3'd5;

    // color lane indexes
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    // controller to datapath commands
    typedef struct packed {
        logic latch_in;   // capture input time
        logic start;      // register products, record frame decision
        logic div_step;   // one restoring division step on all lanes
        logic commit;     // update fade state and load output payload
    } rtfs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic frame_hit;  // elapsed time exceeds the frame wait
    } rtfs_status_t;

endpackage

>>> rtl/rtfs_ctrl.sv
// controller state machine of the rgb triangle fade sequencer
// depends on rtfs_pkg; drives rtfs_dp through command and status structs
module rtfs_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  rtfs_pkg::rtfs_status_t status,
    output rtfs_pkg::rtfs_cmd_t    cmd
);
    import rtfs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.start = 1'b1;
                cnt_next  = '0;
                state_next = status.frame_hit ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/rtfs_dp.sv
// datapath of the rgb triangle fade sequencer: config registers, fade state,
// three-lane multiply and bit-serial divide, output payload; uses rtfs_pkg
module rtfs_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [rtfs_pkg::CFG_ADDR_W-1:0]      wr_addr,
    input  logic [rtfs_pkg::CFG_DATA_W-1:0]      wr_data,
    input  logic [rtfs_pkg::NOW_W-1:0]           now_ms,
    input  rtfs_pkg::rtfs_cmd_t                  cmd,
    output rtfs_pkg::rtfs_status_t               status,
    output logic                                 frame_written,
    output logic [rtfs_pkg::LEVEL_W-1:0]         red_duty,
    output logic [rtfs_pkg::LEVEL_W-1:0]         green_duty,
    output logic [rtfs_pkg::LEVEL_W-1:0]         blue_duty,
    output logic                                 cycle_done
);
    import rtfs_pkg::*;

    // configuration
    logic [WAIT_W-1:0]   frame_wait_reg;
    logic [LEVEL_W-1:0]  fade_steps_reg;
    logic [REPEAT_W-1:0] fade_repeats_reg;
    logic [LEVEL_W-1:0]  base_reg [NUM_LANES];

    // fade state
    logic [TIME_WIDTH-1:0] now_reg;
    logic [TIME_WIDTH-1:0] last_reg, last_next;
    logic [LEVEL_W-1:0]    step_reg, step_next;
    logic                  down_reg, down_next;
    logic [REPEAT_W-1:0]   fades_reg, fades_next;
    logic [LEVEL_W-1:0]    held_reg [NUM_LANES];
    logic                  frame_reg;

    // divider lanes
    logic [PROD_W-1:0]  dvd_reg [NUM_LANES];
    logic [LEVEL_W-1:0] rem_reg [NUM_LANES];
    logic [PROD_W-1:0]  dvd_next [NUM_LANES];
    logic [LEVEL_W-1:0] rem_next [NUM_LANES];
    logic [LEVEL_W:0]   trial [NUM_LANES];
    logic [LEVEL_W-1:0] quot_sat [NUM_LANES];

    // output payload
    logic               out_frame_reg;
    logic               out_done_reg;
    logic               done_next;
    logic [LEVEL_W-1:0] out_duty_reg [NUM_LANES];

    logic [TIME_WIDTH-1:0] elapsed;
    logic [LEVEL_W-1:0]    steps_eff;
    logic                  underflow;
    logic [LEVEL_W-1:0]    step_moved;
    logic [REPEAT_W-1:0]   fades_inc;

    assign steps_eff = (fade_steps_reg == '0) ? LEVEL_W'(1) : fade_steps_reg;
    assign elapsed   = now_reg - last_reg;
    assign status.frame_hit = elapsed > TIME_WIDTH'(frame_wait_reg);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_wait_reg   <= '0;
            fade_steps_reg   <= LEVEL_W'(1);
            fade_repeats_reg <= REPEAT_W'(1);
            for (int i = 0; i < NUM_LANES; i++)
                base_reg[i] <= '0;
        end
        else if (wr_en)
        begin
            case (wr_addr)
                REG_FRAME_WAIT:   frame_wait_reg   <= wr_data[WAIT_W-1:0];
                REG_FADE_STEPS:   fade_steps_reg   <= wr_data[LEVEL_W-1:0];
                REG_FADE_REPEATS: fade_repeats_reg <= wr_data[REPEAT_W-1:0];
                REG_BASE_RED:     base_reg[LANE_RED]   <= wr_data[LEVEL_W-1:0];
                REG_BASE_GREEN:   base_reg[LANE_GREEN] <= wr_data[LEVEL_W-1:0];
                REG_BASE_BLUE:    base_reg[LANE_BLUE]  <= wr_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    // restoring division step, one quotient bit per lane per cycle
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            trial[i] = {rem_reg[i], dvd_reg[i][PROD_W-1]};
            if (trial[i] >= {1'b0, steps_eff})
            begin
                rem_next[i] = LEVEL_W'(trial[i] - {1'b0, steps_eff});
                dvd_next[i] = {dvd_reg[i][PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[i][LEVEL_W-1:0];
                dvd_next[i] = {dvd_reg[i][PROD_W-2:0], 1'b0};
            end
            quot_sat[i] = (|dvd_reg[i][PROD_W-1:LEVEL_W]) ? '1 : dvd_reg[i][LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                dvd_reg[i] <= PROD_W'(base_reg[i]) * PROD_W'(step_reg);
                rem_reg[i] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                dvd_reg[i] <= dvd_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
            now_reg <= TIME_WIDTH'(now_ms);
        if (cmd.start)
            frame_reg <= status.frame_hit;
    end

    // triangle step and fade counting
    always_comb
    begin
        underflow  = down_reg && (step_reg == '0);
        step_moved = step_reg;
        if (down_reg)
        begin
            if (!underflow)
                step_moved = step_reg - 1'b1;
        end
        else if (step_reg != '1)
        begin
            step_moved = step_reg + 1'b1;
        end
        fades_inc = fades_reg + 1'b1;

        last_next  = last_reg;
        step_next  = step_reg;
        down_next  = down_reg;
        fades_next = fades_reg;
        done_next  = 1'b0;
        if (frame_reg)
        begin
            last_next = now_reg;
            step_next = step_moved;
            if (!underflow && (step_moved >= steps_eff))
                down_next = 1'b1;
            if (underflow)
            begin
                step_next  = '0;
                down_next  = 1'b0;
                fades_next = fades_inc;
                if ((fades_inc >= fade_repeats_reg) || (fades_inc == '0))
                begin
                    fades_next = '0;
                    done_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            step_reg  <= '0;
            down_reg  <= 1'b0;
            fades_reg <= '0;
            for (int i = 0; i < NUM_LANES; i++)
                held_reg[i] <= '0;
        end
        else if (cmd.commit)
        begin
            last_reg  <= last_next;
            step_reg  <= step_next;
            down_reg  <= down_next;
            fades_reg <= fades_next;
            if (frame_reg)
            begin
                for (int i = 0; i < NUM_LANES; i++)
                    held_reg[i] <= quot_sat[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_frame_reg <= frame_reg;
            out_done_reg  <= done_next;
            for (int i = 0; i < NUM_LANES; i++)
                out_duty_reg[i] <= frame_reg ? quot_sat[i] : held_reg[i];
        end
    end

    assign frame_written = out_frame_reg;
    assign cycle_done    = out_done_reg;
    assign red_duty      = out_duty_reg[LANE_RED];
    assign green_duty    = out_duty_reg[LANE_GREEN];
    assign blue_duty     = out_duty_reg[LANE_BLUE];

endmodule

>>> rtl/rgb_triangle_fade_sequencer.sv
// top level of the rgb triangle fade sequencer (led breathing fade)
// depends on rtfs_pkg, rtfs_ctrl and rtfs_dp
//
// Each input transfer carries the current millisecond time. When the time
// since the last frame (modulo 2^32) is strictly greater than frame_wait_ms,
// a frame starts: each base color is scaled by step/fade_steps (rounded down,
// saturated at 255), the time is recorded and the step moves one place along
// a triangle from zero up to fade_steps and back. Every return below zero
// counts one finished fade; after fade_repeats fades cycle_done is raised on
// that frame. Every input gives exactly one output transfer; without a frame
// the duties repeat the last color written and tuser/tlast are low.
// Each item is accepted, checked for a frame and then emitted; an item with a
// frame passes in between through the 16-step bit-serial divider that scales
// the three channels side by side. The output register
// holds a finished result while the next item is accepted; a new result
// waits for it to be taken. Configuration writes are taken in any cycle but
// must be made only while the block is idle. Register indexes: 0 frame wait,
// 1 fade steps, 2 fade repeats, 3 red, 4 green, 5 blue; others are ignored.
module rgb_triangle_fade_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              wr_en,
    input  logic [rtfs_pkg::CFG_ADDR_W-1:0]   wr_addr,
    input  logic [rtfs_pkg::CFG_DATA_W-1:0]   wr_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] now_ms
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // blue_duty, green_duty, red_duty
    output logic                              m_tuser,   // frame_written
    output logic                              m_tlast    // cycle_done
);
    import rtfs_pkg::*;

    rtfs_cmd_t    cmd;
    rtfs_status_t status;

    logic [LEVEL_W-1:0] red_duty;
    logic [LEVEL_W-1:0] green_duty;
    logic [LEVEL_W-1:0] blue_duty;

    // sequencing of one item: accept, frame check, divide, emit
    rtfs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // config, fade state, scaling lanes and output payload
    rtfs_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .now_ms        (s_tdata),
        .cmd           (cmd),
        .status        (status),
        .frame_written (m_tuser),
        .red_duty      (red_duty),
        .green_duty    (green_duty),
        .blue_duty     (blue_duty),
        .cycle_done    (m_tlast)
    );

    // red in the lowest byte
    assign m_tdata = {blue_duty, green_duty, red_duty};

endmodule
